[src/gravity_pull_step_macros.svh]
// ---------------------------------------------------------------------------
// gravity_pull_step assertion macros
// shared concurrent assertion forms for the gravity pull step block
// ---------------------------------------------------------------------------
`ifndef GRAVITY_PULL_STEP_MACROS_SVH
`define GRAVITY_PULL_STEP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds outside reset
`define GPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

[src/gps_pkg.sv]
// ---------------------------------------------------------------------------
// gps_pkg
// shared constants and types of the gravity pull step block
// ---------------------------------------------------------------------------
`default_nettype none

package gps_pkg;

  // field widths
  localparam int CFG_W   = 16;
  localparam int MASS_W  = 16;
  localparam int STEP_W  = 32;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 2;
  localparam int SM_W    = 32;

  // fixed point shifts
  localparam int SQRT_SHIFT = 32;
  localparam int NUM_SHIFT  = 24;

  // quotient bits kept, above that is overflow
  localparam int QUOT_W = 33;

  // queue between front and back
  localparam int QUEUE_DEPTH  = 8;
  localparam int FRONT_STAGES = 3;

  // register addresses
  localparam logic [ADDR_W-1:0] ADDR_CONTACT = 2'd0;

  // result flags handed from back to top
  typedef struct packed {
    logic contact;
    logic sat;
  } gps_flags_t;

endpackage

`default_nettype wire

[src/gps_front.sv]
// ---------------------------------------------------------------------------
// gps_front
// offsets, squared distance and contact classification of each item
// ---------------------------------------------------------------------------
`default_nettype none

module gps_front #(
  parameter int CB = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [CB-1:0]              own_x,
  input  logic [CB-1:0]              own_y,
  input  logic [CB-1:0]              other_x,
  input  logic [CB-1:0]              other_y,
  input  logic [gps_pkg::MASS_W-1:0] mass,
  input  logic [2*gps_pkg::CFG_W-1:0] cd_sq,
  output logic                       push,
  output logic [CB:0]                dx,
  output logic [CB:0]                dy,
  output logic [gps_pkg::MASS_W-1:0] mass_out,
  output logic [2*CB+1:0]            d2,
  output logic                       contact
);

  localparam int W2    = 2 * CB + 2;
  localparam int CMP_W = (W2 > 2 * gps_pkg::CFG_W) ? W2 : 2 * gps_pkg::CFG_W;

  logic                       v1, v2;
  logic [CB:0]                dx1, dy1, dx2, dy2;
  logic [gps_pkg::MASS_W-1:0] mass1, mass2;
  logic [CB:0]                ax, ay;
  logic [W2-1:0]              d2_next, d2_2;

  // stage 1: exact offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    dx1   <= {own_x[CB-1], own_x} - {other_x[CB-1], other_x};
    dy1   <= {own_y[CB-1], own_y} - {other_y[CB-1], other_y};
    mass1 <= mass;
  end

  // magnitudes and squared distance
  always_comb begin
    ax      = dx1[CB] ? (CB+1)'(-dx1) : dx1;
    ay      = dy1[CB] ? (CB+1)'(-dy1) : dy1;
    d2_next = W2'(W2'(ax) * W2'(ax)) + W2'(W2'(ay) * W2'(ay));
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dx2   <= dx1;
    dy2   <= dy1;
    mass2 <= mass1;
    d2_2  <= d2_next;
  end

  // stage 3: contact test, coincidence always counts
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v2;
    end
    dx       <= dx2;
    dy       <= dy2;
    mass_out <= mass2;
    d2       <= d2_2;
    contact  <= (CMP_W'(d2_2) <= CMP_W'(cd_sq));
  end

endmodule

`default_nettype wire

[src/gps_queue.sv]
// ---------------------------------------------------------------------------
// gps_queue
// short fifo between front and back, drained every cycle it holds data
// ---------------------------------------------------------------------------
`default_nettype none

module gps_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         pop,
  output logic [W-1:0] pop_data,
  output logic         busy
);

  localparam int D  = gps_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  logic [W-1:0]  mem [0:D-1];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   level;

  // back side takes an entry whenever one is there
  assign pop      = (level != '0);
  assign pop_data = mem[rd_ptr];
  // leave room for the items in flight in the front
  assign busy     = (level >= (AW+1)'(D - gps_pkg::FRONT_STAGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/gps_sqrt.sv]
// ---------------------------------------------------------------------------
// gps_sqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module gps_sqrt #(
  parameter int XW = 66
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [XW-1:0]     x,
  output logic              out_valid,
  output logic [XW/2-1:0]   root
);

  localparam int RW = XW / 2;

  logic [RW-1:0] r_q   [1:RW];
  logic [XW-1:0] rem_q [1:RW];
  logic          v_q   [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [RW-1:0] r_in;
    logic [XW-1:0] rem_in;
    logic          v_in;
    logic [XW:0]   delta;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in   = '0;
      assign rem_in = x;
      assign v_in   = in_valid;
    end else begin : g_next
      assign r_in   = r_q[k];
      assign rem_in = rem_q[k];
      assign v_in   = v_q[k];
    end

    // (r + 2^B)^2 - r^2 against the remainder
    always_comb begin
      delta = ((XW+1)'(r_in) << (B + 1)) + ((XW+1)'(1) << (2 * B));
      take  = ({1'b0, rem_in} >= delta);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_in;
      end
      r_q[k+1]   <= take ? (r_in | (RW'(1) << B)) : r_in;
      rem_q[k+1] <= take ? XW'({1'b0, rem_in} - delta) : rem_in;
    end
  end

  assign out_valid = v_q[RW];
  assign root      = r_q[RW];

endmodule

`default_nettype wire

[src/gps_div.sv]
// ---------------------------------------------------------------------------
// gps_div
// pipelined restoring divider, overflow check then one quotient bit a stage
// ---------------------------------------------------------------------------
`default_nettype none

module gps_div #(
  parameter int NW = 73,
  parameter int DW = 67
) (
  input  logic                       clk,
  input  logic [NW-1:0]              num,
  input  logic [DW-1:0]              den,
  output logic [gps_pkg::QUOT_W-1:0] quot,
  output logic                       ovf
);

  localparam int QW   = gps_pkg::QUOT_W;
  localparam int HW   = NW - QW;
  localparam int CW   = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic [QW-1:0] low_q [0:QW];
  logic [QW-1:0] q_q   [0:QW];
  logic          ovf_q [0:QW];

  // quotient reaches 2^QW when the top part already holds den
  always_ff @(posedge clk) begin
    rem_q[0] <= DW'(num[NW-1:QW]);
    den_q[0] <= den;
    low_q[0] <= num[QW-1:0];
    q_q[0]   <= '0;
    ovf_q[0] <= (CW'(num[NW-1:QW]) >= CW'(den));
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [DW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem_q[k], low_q[k][I]};
      take  = (trial >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk) begin
      rem_q[k+1] <= take ? DW'(trial - {1'b0, den_q[k]}) : DW'(trial);
      den_q[k+1] <= den_q[k];
      low_q[k+1] <= low_q[k];
      q_q[k+1]   <= take ? (q_q[k] | (QW'(1) << I)) : q_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign quot = q_q[QW];
  assign ovf  = ovf_q[QW];

endmodule

`default_nettype wire

[src/gps_back.sv]
// ---------------------------------------------------------------------------
// gps_back
// distance root, denominator, numerators, division and saturation
// ---------------------------------------------------------------------------
`default_nettype none

module gps_back #(
  parameter int CB         = 16,
  parameter int STEP_SCALE = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [CB:0]                dx,
  input  logic [CB:0]                dy,
  input  logic [gps_pkg::MASS_W-1:0] mass,
  input  logic [2*CB+1:0]            d2,
  input  logic                       contact,
  output logic                       done,
  output logic [gps_pkg::STEP_W-1:0] step_x,
  output logic [gps_pkg::STEP_W-1:0] step_y,
  output gps_pkg::gps_flags_t        flags
);

  localparam int W2   = 2 * CB + 2;
  localparam int XW   = W2 + gps_pkg::SQRT_SHIFT;
  localparam int RW   = XW / 2;
  localparam int H    = RW / 2;
  localparam int DW   = W2 + RW;
  localparam int SMW  = gps_pkg::SM_W;
  localparam int PW   = SMW + CB + 1;
  localparam int NW   = PW + gps_pkg::NUM_SHIFT;
  localparam int QW   = gps_pkg::QUOT_W;
  localparam int SW   = gps_pkg::STEP_W;
  localparam int DLAT = QW + 1;

  // flag bits: contact, pos_x, zero_x, pos_y, zero_y
  localparam int FW = 5;

  logic          e_v;
  logic [FW-1:0] e_f;
  logic [CB:0]   e_mx, e_my;
  logic [SMW-1:0] e_sm;
  logic [W2-1:0] e_d2;

  logic          sq_v;
  logic [RW-1:0] sq_root;

  logic [FW-1:0]  a_f  [0:RW-1];
  logic [CB:0]    a_mx [0:RW-1];
  logic [CB:0]    a_my [0:RW-1];
  logic [SMW-1:0] a_sm [0:RW-1];
  logic [W2-1:0]  a_d2 [0:RW-1];

  logic          p1_v, p2_v;
  logic [FW-1:0] p1_f, p2_f;
  logic [W2+H-1:0]      p1_den_lo;
  logic [W2+RW-H-1:0]   p1_den_hi;
  logic [PW-1:0] p1_nx, p1_ny, p2_nx, p2_ny;
  logic [DW-1:0] p2_den;

  logic [QW-1:0] qx, qy;
  logic          ox, oy;
  logic          b_v [0:DLAT-1];
  logic [FW-1:0] b_f [0:DLAT-1];

  logic [SW:0]   res_x, res_y;
  logic [FW-1:0] fin;

  // clip, sign and zero handling of one axis, returns {clip, step}
  function automatic logic [SW:0] axis_out(input logic [QW-1:0] q, input logic ovf,
                                           input logic pos, input logic zero);
    logic [QW-1:0] limit;
    logic          clip;
    logic [QW-1:0] mag;
    limit = pos ? (QW'(1) << (SW - 1)) : ((QW'(1) << (SW - 1)) - 1'b1);
    clip  = !zero && (ovf || (q > limit));
    mag   = clip ? limit : q;
    if (zero) begin
      return '0;
    end
    return {clip, pos ? SW'(-mag) : SW'(mag)};
  endfunction

  // entry stage: magnitudes, signs and scaled mass
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= in_valid;
    end
    e_f  <= {contact, !dx[CB] && (dx != '0), dx == '0, !dy[CB] && (dy != '0), dy == '0};
    e_mx <= dx[CB] ? (CB+1)'(-dx) : dx;
    e_my <= dy[CB] ? (CB+1)'(-dy) : dy;
    e_sm <= SMW'(SMW'(STEP_SCALE) * SMW'(mass));
    e_d2 <= d2;
  end

  // distance in q.16
  gps_sqrt #(.XW(XW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_v),
    .x         ({e_d2, {gps_pkg::SQRT_SHIFT{1'b0}}}),
    .out_valid (sq_v),
    .root      (sq_root)
  );

  // side data alongside the root pipeline
  always_ff @(posedge clk) begin
    a_f[0]  <= e_f;
    a_mx[0] <= e_mx;
    a_my[0] <= e_my;
    a_sm[0] <= e_sm;
    a_d2[0] <= e_d2;
    for (int k = 1; k < RW; k++) begin
      a_f[k]  <= a_f[k-1];
      a_mx[k] <= a_mx[k-1];
      a_my[k] <= a_my[k-1];
      a_sm[k] <= a_sm[k-1];
      a_d2[k] <= a_d2[k-1];
    end
  end

  // product stage: split denominator and both numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= sq_v;
      p2_v <= p1_v;
    end
    p1_f      <= a_f[RW-1];
    p1_den_lo <= (W2+H)'(a_d2[RW-1]) * (W2+H)'(sq_root[H-1:0]);
    p1_den_hi <= (W2+RW-H)'(a_d2[RW-1]) * (W2+RW-H)'(sq_root[RW-1:H]);
    p1_nx     <= PW'(a_sm[RW-1]) * PW'(a_mx[RW-1]);
    p1_ny     <= PW'(a_sm[RW-1]) * PW'(a_my[RW-1]);
    p2_f      <= p1_f;
    p2_den    <= DW'(p1_den_lo) + (DW'(p1_den_hi) << H);
    p2_nx     <= p1_nx;
    p2_ny     <= p1_ny;
  end

  gps_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk  (clk),
    .num  ({p2_nx, {gps_pkg::NUM_SHIFT{1'b0}}}),
    .den  (p2_den),
    .quot (qx),
    .ovf  (ox)
  );

  gps_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk  (clk),
    .num  ({p2_ny, {gps_pkg::NUM_SHIFT{1'b0}}}),
    .den  (p2_den),
    .quot (qy),
    .ovf  (oy)
  );

  // flags and valid alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLAT; k++) begin
        b_v[k] <= 1'b0;
      end
    end else begin
      b_v[0] <= p2_v;
      for (int k = 1; k < DLAT; k++) begin
        b_v[k] <= b_v[k-1];
      end
    end
    b_f[0] <= p2_f;
    for (int k = 1; k < DLAT; k++) begin
      b_f[k] <= b_f[k-1];
    end
  end

  always_comb begin
    fin   = b_f[DLAT-1];
    res_x = axis_out(qx, ox, fin[3], fin[2]);
    res_y = axis_out(qy, oy, fin[1], fin[0]);
  end

  // result register, contact forces zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_v[DLAT-1];
    end
    step_x        <= fin[4] ? '0 : res_x[SW-1:0];
    step_y        <= fin[4] ? '0 : res_y[SW-1:0];
    flags.contact <= fin[4];
    flags.sat     <= !fin[4] && (res_x[SW] || res_y[SW]);
  end

endmodule

`default_nettype wire

[src/gravity_pull_step.sv]
// ---------------------------------------------------------------------------
// gravity_pull_step
// pull step of one body toward an attractor, saturated q24.8 per axis
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  command   start / busy           own_x, own_y, other_x, other_y,
//                                   attractor_mass
//  result    done (one cycle)       step_x, step_y, in_contact, saturated
//  config    apb psel/penable       contact_distance at byte address 0
//
//  one item a cycle while busy is low; each result follows its transfer through
//  the front stages, the queue, the root pipeline (one bit a stage) and the two
//  34-stage dividers (overflow check, then 33 quotient bits)
//  synchronous active high reset clears all valid and control state
//  results cannot be held off; busy rises only if the front queue backs up
//
`default_nettype none

`include "gravity_pull_step_macros.svh"

module gravity_pull_step #(
  parameter int COORD_BITS = 16,
  parameter int STEP_SCALE = 1000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      own_x,
  input  logic signed [COORD_BITS-1:0]      own_y,
  input  logic signed [COORD_BITS-1:0]      other_x,
  input  logic signed [COORD_BITS-1:0]      other_y,
  input  logic [gps_pkg::MASS_W-1:0]        attractor_mass,
  output logic                              done,
  output logic signed [gps_pkg::STEP_W-1:0] step_x,
  output logic signed [gps_pkg::STEP_W-1:0] step_y,
  output logic                              in_contact,
  output logic                              saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gps_pkg::ADDR_W-1:0]        paddr,
  input  logic [gps_pkg::APB_W-1:0]         pwdata,
  output logic [gps_pkg::APB_W-1:0]         prdata,
  output logic                              pready
);

  localparam int CB = COORD_BITS;
  localparam int W2 = 2 * CB + 2;
  localparam int QD = 2 * (CB + 1) + gps_pkg::MASS_W + W2 + 1;

  logic [gps_pkg::CFG_W-1:0]   contact_distance;
  logic [2*gps_pkg::CFG_W-1:0] cd_sq;
  logic                        accept;

  logic                        f_push, f_contact;
  logic [CB:0]                 f_dx, f_dy;
  logic [gps_pkg::MASS_W-1:0]  f_mass;
  logic [W2-1:0]               f_d2;

  logic                        q_pop;
  logic [QD-1:0]               q_data;

  logic [gps_pkg::STEP_W-1:0]  b_sx, b_sy;
  gps_pkg::gps_flags_t         b_flags;

  assign accept = start && !busy;

  // config register, squared copy kept for the contact test
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_distance <= '0;
      cd_sq            <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == gps_pkg::ADDR_CONTACT)) begin
      contact_distance <= pwdata[gps_pkg::CFG_W-1:0];
      cd_sq            <= (2*gps_pkg::CFG_W)'(pwdata[gps_pkg::CFG_W-1:0])
                          * (2*gps_pkg::CFG_W)'(pwdata[gps_pkg::CFG_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == gps_pkg::ADDR_CONTACT) begin
      prdata = gps_pkg::APB_W'(contact_distance);
    end
  end

  gps_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .own_x    (own_x),
    .own_y    (own_y),
    .other_x  (other_x),
    .other_y  (other_y),
    .mass     (attractor_mass),
    .cd_sq    (cd_sq),
    .push     (f_push),
    .dx       (f_dx),
    .dy       (f_dy),
    .mass_out (f_mass),
    .d2       (f_d2),
    .contact  (f_contact)
  );

  gps_queue #(.W(QD)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_contact, f_dx, f_dy, f_mass, f_d2}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .busy      (busy)
  );

  gps_back #(.CB(CB), .STEP_SCALE(STEP_SCALE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_pop),
    .contact  (q_data[QD-1]),
    .dx       (q_data[QD-2 -: CB+1]),
    .dy       (q_data[QD-3-CB -: CB+1]),
    .mass     (q_data[W2 +: gps_pkg::MASS_W]),
    .d2       (q_data[W2-1:0]),
    .done     (done),
    .step_x   (b_sx),
    .step_y   (b_sy),
    .flags    (b_flags)
  );

  assign step_x     = b_sx;
  assign step_y     = b_sy;
  assign in_contact = b_flags.contact;
  assign saturated  = b_flags.sat;

  // checks
  `GPS_ASSERT_IMPLIES(a_contact_zero, done && in_contact, step_x == '0 && step_y == '0 && !saturated, "contact result carries a step")
  `GPS_ASSERT_IMPLIES(a_sat_not_contact, done && saturated, !in_contact, "saturation flagged on contact")
  `GPS_ASSERT_NEVER(a_queue_drains, busy, "front queue backed up")

endmodule

`default_nettype wire
